/* sv/c8vks_pkg.sv */
// Shared types, register indexes and helper functions for the ChaCha8 keystream core.
package c8vks_pkg;

	localparam int unsigned NUM_CFG   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned NUM_WORDS = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WORDS_0_1     = 3'd0,
		CFG_WORDS_2_3     = 3'd1,
		CFG_WORDS_4_5     = 3'd2,
		CFG_WORDS_6_7     = 3'd3,
		CFG_WORDS_8_9     = 3'd4,
		CFG_WORDS_10_11   = 3'd5,
		CFG_WORDS_14_15   = 3'd6,
		CFG_COUNTER_START = 3'd7
	} cfg_idx_t;

	// quarter-round step codes: each step is one add, xor and rotate per lane
	typedef enum logic [1:0] {
		PH_AB_VAR = 2'd0,
		PH_CD_12  = 2'd1,
		PH_AB_8   = 2'd2,
		PH_CD_7   = 2'd3
	} phase_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       diag;
		phase_t     phase;
		logic       final_add;
		logic       emit;
		logic [3:0] emit_idx;
	} c8vks_cmd_t;

	typedef struct packed {
		logic out_full;
	} c8vks_sts_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] t;
		t = {v, v} << n;
		return t[63:32];
	endfunction

	// data-dependent rotation: ((x mod 31) + 1), mod by Barrett, exact for 8-bit x
	function automatic logic [4:0] var_rot(input logic [7:0] x);
		logic [16:0] prod;
		logic [3:0]  q;
		logic [8:0]  qm;
		logic [7:0]  rem;
		prod = 17'(x) * 17'd265;
		q    = prod[16:13];
		qm   = 9'(q) * 9'd31;
		rem  = x - qm[7:0];
		return rem[4:0] + 5'd1;
	endfunction

endpackage

/* sv/c8vks_ctrl.sv */
// Sequencer for load, round steps, feed-forward add and word emission.
module c8vks_ctrl
	import c8vks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	input  c8vks_sts_t sts,
	output c8vks_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	state_t     state_q;
	phase_t     phase_q;
	logic [2:0] rnd_q;
	logic [3:0] idx_q;
	logic       emit_go;

	assign in_ready = (state_q == ST_IDLE);
	assign emit_go  = (state_q == ST_EMIT) && (!sts.out_full || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.step      = (state_q == ST_ROUND);
		cmd.diag      = rnd_q[0];
		cmd.phase     = phase_q;
		cmd.final_add = (state_q == ST_FINAL);
		cmd.emit      = emit_go;
		cmd.emit_idx  = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_AB_VAR;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ROUND;
						phase_q <= PH_AB_VAR;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					phase_q <= phase_t'(phase_q + 2'd1);
					if (phase_q == PH_CD_7) begin
						rnd_q <= rnd_q + 3'd1;
						if (rnd_q == 3'd7) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					state_q <= ST_EMIT;
					idx_q   <= '0;
				end
				ST_EMIT: begin
					if (emit_go) begin
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'd15) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/c8vks_dp.sv */
// Datapath: config registers, block counter, 4x4 working state, four quarter-round lanes.
module c8vks_dp
	import c8vks_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 restart,
	input  c8vks_cmd_t           cmd,
	output c8vks_sts_t           sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [31:0]          key_word,
	output logic [3:0]           word_index,
	output logic                 last_word
);

	logic [63:0] cfg_q [NUM_CFG];
	logic [63:0] ctr_q;
	logic [63:0] base_ctr;
	logic [31:0] w_q   [NUM_WORDS];
	logic [31:0] init  [NUM_WORDS];

	// lane operands and results, row k of lane j
	logic [31:0] opnd  [4][4];
	logic [31:0] res   [4][4];
	logic [31:0] nxt   [4][4];

	logic        out_valid_q;
	logic [31:0] key_word_q;
	logic [3:0]  word_index_q;
	logic        last_word_q;

	assign base_ctr = (cmd.load && restart) ? cfg_q[CFG_COUNTER_START] : ctr_q;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			init[2*i]   = cfg_q[i][31:0];
			init[2*i+1] = cfg_q[i][63:32];
		end
		init[12] = base_ctr[31:0];
		init[13] = base_ctr[63:32];
		init[14] = cfg_q[CFG_WORDS_14_15][31:0];
		init[15] = cfg_q[CFG_WORDS_14_15][63:32];
	end

	// gather: column round uses column j; diagonal round shifts row k by k
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 4; k++) begin
				opnd[j][k] = cmd.diag ? w_q[4*k + ((j + k) % 4)] : w_q[4*k + j];
			end
		end
	end

	always_comb begin
		logic [31:0] s_ab;
		logic [31:0] s_cd;
		logic [4:0]  r_d;
		logic [4:0]  r_b;
		for (int j = 0; j < 4; j++) begin
			s_ab = opnd[j][0] + opnd[j][1];
			s_cd = opnd[j][2] + opnd[j][3];
			r_d  = (cmd.phase == PH_AB_VAR) ? var_rot(opnd[j][2][7:0] ^ opnd[j][1][7:0])
			                                : 5'd8;
			r_b  = (cmd.phase == PH_CD_12) ? 5'd12 : 5'd7;
			res[j][0] = s_ab;
			res[j][1] = rotl32(opnd[j][1] ^ s_cd, r_b);
			res[j][2] = s_cd;
			res[j][3] = rotl32(opnd[j][3] ^ s_ab, r_d);
		end
	end

	// scatter back to row/column positions
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int m = 0; m < 4; m++) begin
				nxt[k][m] = cmd.diag ? res[(m - k + 4) % 4][k] : res[m][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.load && restart) begin
			ctr_q <= cfg_q[CFG_COUNTER_START];
		end else if (cmd.final_add) begin
			ctr_q <= ctr_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				w_q[i] <= init[i];
			end
		end else if (cmd.step) begin
			// a/d phases touch rows 0 and 3, c/b phases rows 1 and 2
			for (int m = 0; m < 4; m++) begin
				if (cmd.phase == PH_AB_VAR || cmd.phase == PH_AB_8) begin
					w_q[m]      <= nxt[0][m];
					w_q[12 + m] <= nxt[3][m];
				end else begin
					w_q[4 + m]  <= nxt[1][m];
					w_q[8 + m]  <= nxt[2][m];
				end
			end
		end else if (cmd.final_add) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				w_q[i] <= w_q[i] + init[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			key_word_q   <= w_q[cmd.emit_idx];
			word_index_q <= cmd.emit_idx;
			last_word_q  <= (cmd.emit_idx == 4'd15);
		end
	end

	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign key_word     = key_word_q;
	assign word_index   = word_index_q;
	assign last_word    = last_word_q;

endmodule

/* sv/chacha8_varrot_keystream_block_core.sv */
// Top level of the ChaCha8 variable-rotation keystream block core.
//
// channel  direction  handshake             payload
// cfg      in         cfg_valid/cfg_ready   cfg_index[2:0], cfg_data[63:0]
// in       in         in_valid/in_ready     restart
// out      out        out_valid/out_ready   key_word[31:0], word_index[3:0], last_word
//
// One request gives 16 words. The request is accepted, then 8 rounds of 4 quarter-round
// steps run on the four shared lanes, then the feed-forward add, then the 16 words are
// emitted. A stall on out_ready holds the emit sequencer; the next request is taken
// once the last word sits in the output register. Reset clears config registers, the
// block counter and control; cfg is always ready.
module chacha8_varrot_keystream_block_core
	import c8vks_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          key_word,
	output logic [3:0]           word_index,
	output logic                 last_word
);

	c8vks_cmd_t cmd;
	c8vks_sts_t sts;

	assign cfg_ready = 1'b1;

	c8vks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	c8vks_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.restart    (restart),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.key_word   (key_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

endmodule

/* dv/chacha8_varrot_keystream_block_core_tb.sv */
// Self-checking testbench for the ChaCha8 variable-rotation keystream block core.
`timescale 1ns / 1ps

module chacha8_varrot_keystream_block_core_tb
	import c8vks_pkg::*;
();

	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 39;
	localparam int HOLD_PHASE      = 4;
	localparam int PAUSE_PHASE     = 8;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 60;
	localparam int DIR_ROWS        = 24;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] key_word;
		logic [3:0]  word_index;
		logic        last_word;
	} key_out_t;

	typedef struct packed {
		logic        is_cfg;
		cfg_idx_t    idx;
		logic [63:0] data;
		logic        rs;
		logic        zero_exp;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 restart;
	logic                 out_valid;
	logic                 out_ready;
	logic [31:0]          key_word;
	logic [3:0]           word_index;
	logic                 last_word;

	// predictor state
	logic [63:0] reg_copy [NUM_CFG];
	logic [63:0] blk_ctr;
	logic [31:0] mix [NUM_WORDS];
	key_out_t    key_due_q [$];

	int   err_cnt;
	int   words_due;
	int   words_seen;
	int   hold_req_cnt;
	bit   send_idle;
	bit   recv_idle;
	logic zero_tag;	// travels with restart: whole block known to be zero

	// directed items; block rows with zero_exp set are known all-zero blocks
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b0, 1'b1},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b1, 1'b1},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b0, 1'b0},
		'{1'b1, CFG_WORDS_0_1,     ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_WORDS_2_3,     ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_WORDS_4_5,     ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_WORDS_6_7,     ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_WORDS_8_9,     ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_WORDS_10_11,   ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_WORDS_14_15,   ALL_ONES,               1'b0, 1'b0},
		'{1'b1, CFG_COUNTER_START, ALL_ONES,               1'b0, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b1, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b0, 1'b0},
		'{1'b1, CFG_COUNTER_START, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b1, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b0, 1'b0},
		'{1'b1, CFG_WORDS_0_1,     64'h3320_646E_6170_7865, 1'b0, 1'b0},
		'{1'b1, CFG_WORDS_2_3,     64'h6B20_6574_7962_2D32, 1'b0, 1'b0},
		'{1'b1, CFG_WORDS_6_7,     64'hAAAA_5555_5555_AAAA, 1'b0, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b0, 1'b0},
		'{1'b1, CFG_COUNTER_START, 64'd0,                  1'b0, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b1, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b1, 1'b0},
		'{1'b0, CFG_WORDS_0_1,     64'd0,                  1'b0, 1'b0}
	};

	chacha8_varrot_keystream_block_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_word   (key_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter_mix(input int ia, input int ib, input int ic, input int id);
		logic [31:0] a, b, c, d;
		int unsigned r;
		a = mix[ia];
		b = mix[ib];
		c = mix[ic];
		d = mix[id];
		// first rotate amount comes from the low byte of c^b, in 1..31
		r = ((c ^ b) & 32'hFF) % 31 + 1;
		a = a + b;
		d = rol(d ^ a, r);
		c = c + d;
		b = rol(b ^ c, 12);
		a = a + b;
		d = rol(d ^ a, 8);
		c = c + d;
		b = rol(b ^ c, 7);
		mix[ia] = a;
		mix[ib] = b;
		mix[ic] = c;
		mix[id] = d;
	endfunction

	function automatic void keystream_block();
		logic [31:0] init [NUM_WORDS];
		int k;
		for (k = 0; k < 6; k++) begin
			init[2*k]   = reg_copy[k][31:0];
			init[2*k+1] = reg_copy[k][63:32];
		end
		init[12] = blk_ctr[31:0];
		init[13] = blk_ctr[63:32];
		init[14] = reg_copy[CFG_WORDS_14_15][31:0];
		init[15] = reg_copy[CFG_WORDS_14_15][63:32];
		mix = init;
		repeat (4) begin
			quarter_mix(0, 4, 8, 12);
			quarter_mix(1, 5, 9, 13);
			quarter_mix(2, 6, 10, 14);
			quarter_mix(3, 7, 11, 15);
			quarter_mix(0, 5, 10, 15);
			quarter_mix(1, 6, 11, 12);
			quarter_mix(2, 7, 8, 13);
			quarter_mix(3, 4, 9, 14);
		end
		for (k = 0; k < NUM_WORDS; k++)
			mix[k] = mix[k] + init[k];
	endfunction

	function automatic logic [63:0] pick_reg_value(input cfg_idx_t idx);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = ALL_ONES;
			2: v = 64'h5555_5555_AAAA_AAAA;
			3: if (idx == CFG_COUNTER_START) v = ALL_ONES - $urandom_range(0, 6);
			4: if (idx == CFG_COUNTER_START) v = 64'h0000_0000_FFFF_FFFF - $urandom_range(0, 6);
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		for (int k = 0; k < NUM_CFG; k++)
			reg_copy[k] = '0;
		blk_ctr    = '0;
		err_cnt    = 0;
		words_due  = 0;
		words_seen = 0;
	end

	// output check first, then config and item tracking
	always @(posedge clk) begin
		key_out_t want;
		int k;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				words_seen <= words_seen + 1;
				if (key_due_q.size() == 0) begin
					err_cnt++;
					$display("%0t unexpected word: expected none, actual %h index %0d last %b",
						$time, key_word, word_index, last_word);
				end else begin
					want = key_due_q.pop_front();
					if (key_word !== want.key_word) begin
						err_cnt++;
						$display("%0t key_word[%0d]: expected %h, actual %h",
							$time, want.word_index, want.key_word, key_word);
					end
					if (word_index !== want.word_index) begin
						err_cnt++;
						$display("%0t word_index: expected %0d, actual %0d",
							$time, want.word_index, word_index);
					end
					if (last_word !== want.last_word) begin
						err_cnt++;
						$display("%0t last_word at word %0d: expected %b, actual %b",
							$time, want.word_index, want.last_word, last_word);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				reg_copy[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				if (restart)
					blk_ctr = reg_copy[CFG_COUNTER_START];
				keystream_block();
				for (k = 0; k < NUM_WORDS; k++) begin
					want.key_word   = zero_tag ? 32'd0 : mix[k];
					want.word_index = 4'(k);
					want.last_word  = (k == NUM_WORDS - 1);
					key_due_q.push_back(want);
				end
				blk_ctr = blk_ctr + 64'd1;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int hold_done;
		hold_done = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req_cnt != hold_done) begin
				hold_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (recv_idle && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic push_block(input logic rs, input logic zero);
		in_valid <= 1'b1;
		restart  <= rs;
		zero_tag <= zero;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_due += NUM_WORDS;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering items and wait for every outstanding word
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (words_seen < words_due) @(posedge clk);
	endtask

	initial begin
		dir_row_t row;
		int ph, n, k;
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_WORDS_0_1;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		restart      <= 1'b0;
		zero_tag     <= 1'b0;
		send_idle    = 1'b1;
		recv_idle    = 1'b1;
		hold_req_cnt = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIR_ROWS; n++) begin
			row = dir_rows[n];
			if (row.is_cfg) begin
				wait_quiet();
				write_reg(row.idx, row.data);
			end else begin
				push_block(row.rs, row.zero_exp);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_quiet();
			for (k = 0; k < NUM_CFG; k++)
				if (ph == 0 || $urandom_range(0, 3) != 0)
					write_reg(cfg_idx_t'(k), pick_reg_value(cfg_idx_t'(k)));
			send_idle = (ph != NUM_PHASES - 1) && (ph != HOLD_PHASE) &&
				($urandom_range(0, 3) != 0);
			recv_idle = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			// long receiver hold-off while items keep coming back to back
			if (ph == HOLD_PHASE)
				hold_req_cnt++;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
					wait_quiet();
				push_block($urandom_range(0, 6) == 0, 1'b0);
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (key_due_q.size() != 0) begin
			err_cnt++;
			$display("%0t words never returned: expected %0d more, actual 0",
				$time, key_due_q.size());
		end
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
